/* sv/rrcp_pkg.sv */
// Package for the round-robin cooldown picker.
// Holds table sizing, entry state codes, the controller state type and the
// command/status structs shared by the controller, datapath and top level.
`default_nettype none

package rrcp_pkg;

   // Table sizing.
   localparam int ENTRY_COUNT = 16;
   localparam int IDX_W       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
   localparam int CNT_W       = $clog2(ENTRY_COUNT + 1);

   // Field widths fixed by the interface.
   localparam int INDEX_FIELD_W = 4;
   localparam int STATE_FIELD_W = 2;
   localparam int TIME_W        = 32;
   localparam int COUNT_FIELD_W = 5;

   // Entry state codes.
   localparam logic [STATE_FIELD_W-1:0] ST_IDLE     = 2'd0;
   localparam logic [STATE_FIELD_W-1:0] ST_ACTIVE   = 2'd1;
   localparam logic [STATE_FIELD_W-1:0] ST_COOLDOWN = 2'd2;

   // Action codes.
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_PICK  = 1'b1;

   // Controller states.
   typedef enum logic [1:0] {
      CTRL_IDLE,
      CTRL_SCAN,
      CTRL_FINISH
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } rrcp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_step;
   } rrcp_status_type;

endpackage

`default_nettype wire

/* sv/rrcp_ctrl.sv */
// Controller state machine for the round-robin cooldown picker.
// Sequences the load, scan and finish phases; uses rrcp_pkg.
`default_nettype none

module rrcp_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire rrcp_pkg::rrcp_status_type status,
   output rrcp_pkg::rrcp_cmd_type        cmd,
   output logic                          busy
);

   rrcp_pkg::ctrl_state_type state_ff;
   rrcp_pkg::ctrl_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrcp_pkg::CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.step   = 1'b0;
      cmd.finish = 1'b0;
      busy       = 1'b1;
      case (state_ff)
         rrcp_pkg::CTRL_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = rrcp_pkg::CTRL_SCAN;
            end
         end
         rrcp_pkg::CTRL_SCAN: begin
            cmd.step = 1'b1;
            if (status.last_step) begin
               state_in = rrcp_pkg::CTRL_FINISH;
            end
         end
         rrcp_pkg::CTRL_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = rrcp_pkg::CTRL_IDLE;
         end
         default: begin
            state_in = rrcp_pkg::CTRL_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* sv/rrcp_datapath.sv */
// Datapath for the round-robin cooldown picker: entry table, scan cursor,
// scan pointer, state counter and result registers; uses rrcp_pkg.
`default_nettype none

module rrcp_datapath (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire rrcp_pkg::rrcp_cmd_type                  cmd,
   output rrcp_pkg::rrcp_status_type                    status,
   input  wire logic                                    req_action,
   input  wire logic [rrcp_pkg::INDEX_FIELD_W-1:0]      req_entry_index,
   input  wire logic [rrcp_pkg::STATE_FIELD_W-1:0]      req_new_state,
   input  wire logic [rrcp_pkg::TIME_W-1:0]             req_eligible_time,
   input  wire logic [rrcp_pkg::TIME_W-1:0]             req_now_time,
   input  wire logic [rrcp_pkg::STATE_FIELD_W-1:0]      req_query_state,
   output logic                                         rsp_valid,
   output logic                                         rsp_found,
   output logic [rrcp_pkg::INDEX_FIELD_W-1:0]           rsp_picked_index,
   output logic [rrcp_pkg::COUNT_FIELD_W-1:0]           rsp_state_count
);

   localparam int N     = rrcp_pkg::ENTRY_COUNT;
   localparam int IW    = rrcp_pkg::IDX_W;
   localparam int CW    = rrcp_pkg::CNT_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(N - 1);

   // Entry table and cursor.
   logic [rrcp_pkg::STATE_FIELD_W-1:0] entry_state_ff    [N];
   logic [rrcp_pkg::TIME_W-1:0]        entry_eligible_ff [N];
   logic [IW-1:0]                      cursor_ff;

   // Captured request fields.
   logic                               action_ff;
   logic [rrcp_pkg::TIME_W-1:0]        now_ff;
   logic [rrcp_pkg::STATE_FIELD_W-1:0] query_ff;

   // Scan progress.
   logic [IW-1:0] ptr_ff;
   logic [IW-1:0] step_ff;
   logic [CW-1:0] count_ff;
   logic          found_ff;
   logic [IW-1:0] pick_ff;
   logic          pick_cool_ff;

   // Result registers.
   logic                               rsp_valid_ff;
   logic                               rsp_found_ff;
   logic [rrcp_pkg::INDEX_FIELD_W-1:0] rsp_picked_ff;
   logic [rrcp_pkg::COUNT_FIELD_W-1:0] rsp_count_ff;

   logic                               write_hit;
   logic [IW-1:0]                      write_idx;
   logic [rrcp_pkg::STATE_FIELD_W-1:0] cur_state;
   logic [rrcp_pkg::TIME_W-1:0]        cur_elig;
   logic                               cur_eligible;
   logic [IW-1:0]                      ptr_next;
   logic [IW-1:0]                      cursor_next;
   logic [CW-1:0]                      count_fixed;

   // A write lands at the transfer edge when its index is inside the table.
   assign write_hit = cmd.load && (req_action == rrcp_pkg::ACT_WRITE) &&
                      (32'(req_entry_index) < 32'(N));
   assign write_idx = IW'(req_entry_index);

   // Entry under the scan pointer and its eligibility.
   assign cur_state    = entry_state_ff[ptr_ff];
   assign cur_elig     = entry_eligible_ff[ptr_ff];
   assign cur_eligible = (cur_state == rrcp_pkg::ST_IDLE) ||
                         ((cur_state == rrcp_pkg::ST_COOLDOWN) && (now_ff >= cur_elig));
   assign ptr_next     = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;
   assign cursor_next  = (pick_ff == LAST_IDX) ? '0 : pick_ff + 1'b1;

   assign status.last_step = (step_ff == LAST_IDX);

   // The count is taken before the pick lands; a cooldown entry turned idle
   // moves one count from cooldown to idle.
   always_comb begin
      count_fixed = count_ff;
      if (found_ff && pick_cool_ff) begin
         if (query_ff == rrcp_pkg::ST_IDLE) begin
            count_fixed = count_ff + 1'b1;
         end else if (query_ff == rrcp_pkg::ST_COOLDOWN) begin
            count_fixed = count_ff - 1'b1;
         end
      end
   end

   // Entry table, cursor and result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            entry_state_ff[i]    <= rrcp_pkg::ST_IDLE;
            entry_eligible_ff[i] <= '0;
         end
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
         if (write_hit) begin
            entry_state_ff[write_idx]    <= req_new_state;
            entry_eligible_ff[write_idx] <= req_eligible_time;
         end
         if (cmd.finish && found_ff) begin
            entry_state_ff[pick_ff] <= rrcp_pkg::ST_IDLE;
            cursor_ff               <= cursor_next;
         end
      end
   end

   // Scan over all entries from the cursor: count and find the first pick.
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.load) begin
         found_ff <= 1'b0;
      end else if (cmd.step && (action_ff == rrcp_pkg::ACT_PICK) && !found_ff &&
                   cur_eligible) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         now_ff    <= req_now_time;
         query_ff  <= req_query_state;
         ptr_ff    <= cursor_ff;
         step_ff   <= '0;
         count_ff  <= '0;
      end else if (cmd.step) begin
         ptr_ff  <= ptr_next;
         step_ff <= step_ff + 1'b1;
         if (cur_state == query_ff) begin
            count_ff <= count_ff + 1'b1;
         end
         if ((action_ff == rrcp_pkg::ACT_PICK) && !found_ff && cur_eligible) begin
            pick_ff      <= ptr_ff;
            pick_cool_ff <= (cur_state == rrcp_pkg::ST_COOLDOWN);
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_found_ff  <= found_ff;
         rsp_picked_ff <= found_ff ? rrcp_pkg::INDEX_FIELD_W'(pick_ff) : '0;
         rsp_count_ff  <= rrcp_pkg::COUNT_FIELD_W'(count_fixed);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_picked_index = rsp_picked_ff;
   assign rsp_state_count  = rsp_count_ff;

endmodule

`default_nettype wire

/* sv/round_robin_cooldown_picker_core.sv */
// Top level of the round-robin cooldown picker.
// Joins rrcp_ctrl and rrcp_datapath; uses rrcp_pkg.
//
// A request transfers when start is high and busy is low. A write updates
// its entry at that edge; a pick scans the whole table from the cursor.
// Every request passes through a transfer step, a scan step for each table
// entry, in which that entry is read, compared against now and counted, and
// a finish step that applies the pick. The result then shows on the rsp_
// ports for exactly one cycle with rsp_valid high and must be taken then; the
// receiver cannot stall. busy is low again in that same cycle, so the next
// request may transfer while the result is out.
`default_nettype none

module round_robin_cooldown_picker_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic                               req_action,
   input  wire logic [rrcp_pkg::INDEX_FIELD_W-1:0] req_entry_index,
   input  wire logic [rrcp_pkg::STATE_FIELD_W-1:0] req_new_state,
   input  wire logic [rrcp_pkg::TIME_W-1:0]        req_eligible_time,
   input  wire logic [rrcp_pkg::TIME_W-1:0]        req_now_time,
   input  wire logic [rrcp_pkg::STATE_FIELD_W-1:0] req_query_state,
   output logic                                    rsp_valid,
   output logic                                    rsp_found,
   output logic [rrcp_pkg::INDEX_FIELD_W-1:0]      rsp_picked_index,
   output logic [rrcp_pkg::COUNT_FIELD_W-1:0]      rsp_state_count
);

   rrcp_pkg::rrcp_cmd_type    cmd;
   rrcp_pkg::rrcp_status_type status;

   // Sequencer.
   rrcp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // Table and scan datapath.
   rrcp_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_action        (req_action),
      .req_entry_index   (req_entry_index),
      .req_new_state     (req_new_state),
      .req_eligible_time (req_eligible_time),
      .req_now_time      (req_now_time),
      .req_query_state   (req_query_state),
      .rsp_valid         (rsp_valid),
      .rsp_found         (rsp_found),
      .rsp_picked_index  (rsp_picked_index),
      .rsp_state_count   (rsp_state_count)
   );

endmodule

`default_nettype wire

/* tb/rrcp_pick_checker.sv */
// Checker for the round-robin cooldown picker: watches request and result transfers,
// keeps its own copy of the entry table and cursor, and compares every result.
// Depends on rrcp_pkg for widths and state and action codes.
`default_nettype none

module rrcp_pick_checker
   import rrcp_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic                     busy,
   input  wire logic                     req_action,
   input  wire logic [INDEX_FIELD_W-1:0] req_entry_index,
   input  wire logic [STATE_FIELD_W-1:0] req_new_state,
   input  wire logic [TIME_W-1:0]        req_eligible_time,
   input  wire logic [TIME_W-1:0]        req_now_time,
   input  wire logic [STATE_FIELD_W-1:0] req_query_state,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_found,
   input  wire logic [INDEX_FIELD_W-1:0] rsp_picked_index,
   input  wire logic [COUNT_FIELD_W-1:0] rsp_state_count,
   output int                            error_count,
   output int                            awaited_count
);

   typedef struct packed {
      logic                     found;
      logic [INDEX_FIELD_W-1:0] index;
      logic [COUNT_FIELD_W-1:0] count;
   } pick_result_type;

   // Shadow copy of the entry table and the scan cursor.
   logic [STATE_FIELD_W-1:0] entry_mode [ENTRY_COUNT];
   logic [TIME_W-1:0]        entry_ready_at [ENTRY_COUNT];
   logic [IDX_W-1:0]         cursor;
   pick_result_type          results_awaited [$];
   int                       mismatches = 0;
   int                       awaited = 0;

   assign error_count   = mismatches;
   assign awaited_count = awaited;

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // Applies one request to the shadow table and queues the result it must produce.
   task automatic predict_request(
      input logic                     act,
      input logic [INDEX_FIELD_W-1:0] idx,
      input logic [STATE_FIELD_W-1:0] mode,
      input logic [TIME_W-1:0]        ready_at,
      input logic [TIME_W-1:0]        now,
      input logic [STATE_FIELD_W-1:0] query
   );
      pick_result_type  res;
      int               slot;
      int               tally;
      logic [IDX_W-1:0] pos;
      res = '0;
      if (act == ACT_WRITE) begin
         if (int'(idx) < ENTRY_COUNT) begin
            entry_mode[idx]     = mode;
            entry_ready_at[idx] = ready_at;
         end
      end else begin
         // Scan from the cursor with wraparound; the first eligible entry wins.
         for (slot = 0; slot < ENTRY_COUNT && !res.found; slot++) begin
            pos = IDX_W'((int'(cursor) + slot) % ENTRY_COUNT);
            if (entry_mode[pos] == ST_IDLE ||
                (entry_mode[pos] == ST_COOLDOWN && now >= entry_ready_at[pos])) begin
               entry_mode[pos] = ST_IDLE;
               cursor          = IDX_W'((int'(pos) + 1) % ENTRY_COUNT);
               res.found       = 1'b1;
               res.index       = INDEX_FIELD_W'(pos);
            end
         end
      end
      // The count is taken after the step has been applied.
      tally = 0;
      for (slot = 0; slot < ENTRY_COUNT; slot++) begin
         if (entry_mode[slot] == query) tally++;
      end
      res.count = COUNT_FIELD_W'(tally);
      results_awaited.push_back(res);
   endtask

   // Results are checked before a request in the same cycle is predicted, so the
   // oldest expectation always belongs to an earlier request.
   always @(posedge clock) begin
      pick_result_type want;
      if (reset) begin
         for (int i = 0; i < ENTRY_COUNT; i++) begin
            entry_mode[i]     = ST_IDLE;
            entry_ready_at[i] = '0;
         end
         cursor = '0;
         results_awaited.delete();
      end else begin
         if (rsp_valid) begin
            if (results_awaited.size() == 0) begin
               report_mismatch("unexpected result, picked_index", int'(rsp_picked_index), -1);
            end else begin
               want = results_awaited.pop_front();
               if (rsp_found !== want.found)
                  report_mismatch("found", int'(rsp_found), int'(want.found));
               if (rsp_picked_index !== want.index)
                  report_mismatch("picked_index", int'(rsp_picked_index), int'(want.index));
               if (rsp_state_count !== want.count)
                  report_mismatch("state_count", int'(rsp_state_count), int'(want.count));
            end
         end
         if (start && !busy) begin
            predict_request(req_action, req_entry_index, req_new_state,
                            req_eligible_time, req_now_time, req_query_state);
         end
      end
      awaited = results_awaited.size();
   end

endmodule

`default_nettype wire

/* tb/round_robin_cooldown_picker_core_tb.sv */
// Testbench top for round_robin_cooldown_picker_core: drives directed and random
// requests and gives the verdict. Depends on rrcp_pkg and rrcp_pick_checker.
`default_nettype none

module round_robin_cooldown_picker_core_tb;
   import rrcp_pkg::*;

   // State code outside the defined set; stored as is and never picked.
   localparam logic [STATE_FIELD_W-1:0] ST_RESERVED = 2'd3;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     req_action = ACT_WRITE;
   logic [INDEX_FIELD_W-1:0] req_entry_index = '0;
   logic [STATE_FIELD_W-1:0] req_new_state = ST_IDLE;
   logic [TIME_W-1:0]        req_eligible_time = '0;
   logic [TIME_W-1:0]        req_now_time = '0;
   logic [STATE_FIELD_W-1:0] req_query_state = ST_IDLE;
   wire logic                busy;
   wire logic                rsp_valid;
   wire logic                rsp_found;
   wire logic [INDEX_FIELD_W-1:0] rsp_picked_index;
   wire logic [COUNT_FIELD_W-1:0] rsp_state_count;
   int                       error_count;
   int                       awaited_count;
   logic                     steady = 1'b0;
   logic [TIME_W-1:0]        now_ms;

   round_robin_cooldown_picker_core dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_entry_index   (req_entry_index),
      .req_new_state     (req_new_state),
      .req_eligible_time (req_eligible_time),
      .req_now_time      (req_now_time),
      .req_query_state   (req_query_state),
      .rsp_valid         (rsp_valid),
      .rsp_found         (rsp_found),
      .rsp_picked_index  (rsp_picked_index),
      .rsp_state_count   (rsp_state_count)
   );

   rrcp_pick_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_entry_index   (req_entry_index),
      .req_new_state     (req_new_state),
      .req_eligible_time (req_eligible_time),
      .req_now_time      (req_now_time),
      .req_query_state   (req_query_state),
      .rsp_valid         (rsp_valid),
      .rsp_found         (rsp_found),
      .rsp_picked_index  (rsp_picked_index),
      .rsp_state_count   (rsp_state_count),
      .error_count       (error_count),
      .awaited_count     (awaited_count)
   );

   // Free-running clock with a period of 20.
   initial begin
      forever #10 clock = ~clock;
   end

   // Hard limit on the length of the run.
   initial begin
      #4000000;
      $display("DONE: errors detected");
      $finish;
   end

   // Issues one request at a falling edge and returns at the falling edge after
   // its transfer. busy is stable between edges, so reading it here is safe.
   task automatic issue(
      input logic                     act,
      input logic [INDEX_FIELD_W-1:0] idx,
      input logic [STATE_FIELD_W-1:0] mode,
      input logic [TIME_W-1:0]        ready_at,
      input logic [TIME_W-1:0]        now,
      input logic [STATE_FIELD_W-1:0] query
   );
      if (!steady && $urandom_range(0, 99) < 9) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 24)) @(negedge clock);
      end
      start             <= 1'b1;
      req_action        <= act;
      req_entry_index   <= idx;
      req_new_state     <= mode;
      req_eligible_time <= ready_at;
      req_now_time      <= now;
      req_query_state   <= query;
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   // Holds requests off until every awaited result has come back.
   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (awaited_count != 0) @(negedge clock);
   endtask

   // Entry state for random writes, weighted toward active and cooldown.
   function automatic logic [STATE_FIELD_W-1:0] random_mode();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 20) return ST_IDLE;
      else if (roll < 55) return ST_ACTIVE;
      else if (roll < 90) return ST_COOLDOWN;
      else return ST_RESERVED;
   endfunction

   // Mostly a time close to the running clock so that compares go both ways,
   // sometimes a full-range or extreme value.
   function automatic logic [TIME_W-1:0] near_time(input logic [TIME_W-1:0] base);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 15) return TIME_W'($urandom);
      else if (roll < 18) return '0;
      else if (roll < 20) return '1;
      else return base + TIME_W'($urandom_range(0, 48)) - TIME_W'(16);
   endfunction

   // Stimulus and verdict.
   initial begin
      int n;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      // Directed: pick from a fresh table, then fill every entry.
      issue(ACT_PICK, '0, ST_IDLE, '0, '0, ST_IDLE);
      for (n = 0; n < ENTRY_COUNT; n++) begin
         if (n == 15)
            issue(ACT_WRITE, 4'(n), ST_COOLDOWN, 32'hFFFF_FFFF, '0, ST_COOLDOWN);
         else if (n == 7)
            issue(ACT_WRITE, 4'(n), ST_COOLDOWN, 32'h0000_1000, '1, ST_ACTIVE);
         else if (n == 3)
            issue(ACT_WRITE, 4'(n), ST_RESERVED, '0, '0, ST_RESERVED);
         else
            issue(ACT_WRITE, 4'(n), ST_ACTIVE, (n % 2) ? '1 : '0, '0, 2'(n % 4));
      end
      // Nothing eligible, then a cooldown one below and exactly at its eligible time.
      issue(ACT_PICK, '1, ST_IDLE, '0, '0, ST_ACTIVE);
      issue(ACT_PICK, '0, ST_IDLE, '0, 32'h0000_0FFF, ST_COOLDOWN);
      issue(ACT_PICK, '0, ST_IDLE, '0, 32'h0000_1000, ST_COOLDOWN);
      // An idle entry behind the cursor is reached by wrapping around.
      issue(ACT_WRITE, 4'd1, ST_IDLE, '1, '0, ST_IDLE);
      issue(ACT_PICK, '0, ST_IDLE, '0, '0, ST_IDLE);
      issue(ACT_PICK, '1, ST_ACTIVE, '1, '1, ST_RESERVED);
      // The top entry is taken at the largest time.
      issue(ACT_PICK, '0, ST_IDLE, '0, '1, ST_IDLE);
      drain();

      // Random: half writes, half picks, against a slowly advancing clock.
      now_ms = TIME_W'($urandom_range(0, 1000));
      for (n = 0; n < 1150; n++) begin
         steady = (n >= 400 && n < 650);
         if (n % 300 == 299) drain();
         now_ms = now_ms + TIME_W'($urandom_range(0, 6));
         if ($urandom_range(0, 1) == 0)
            issue(ACT_WRITE, INDEX_FIELD_W'($urandom_range(0, 15)), random_mode(),
                  near_time(now_ms), TIME_W'($urandom), STATE_FIELD_W'($urandom_range(0, 3)));
         else
            issue(ACT_PICK, INDEX_FIELD_W'($urandom_range(0, 15)), random_mode(),
                  TIME_W'($urandom), near_time(now_ms), STATE_FIELD_W'($urandom_range(0, 3)));
      end

      // Let the last results arrive, then allow for one more full request time.
      drain();
      repeat (40) @(negedge clock);
      if (error_count == 0 && awaited_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
sv/rrcp_pkg.sv
sv/rrcp_ctrl.sv
sv/rrcp_datapath.sv
sv/round_robin_cooldown_picker_core.sv
tb/rrcp_pick_checker.sv
tb/round_robin_cooldown_picker_core_tb.sv
